// ===== src/vapm_pkg.sv =====
`default_nettype none

package vapm_pkg;

    // Build-time sizing
    localparam int NUM_INPUTS  = 8;
    localparam int SAMPLE_BITS = 24;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 3;
    localparam int SAMPLE_W   = 24;
    localparam int KIND_W     = 2;
    localparam int LEVEL_W    = 24;
    localparam int ID_W       = 8;
    localparam int PERIOD_W   = 16;
    localparam int SILENT_W   = 2;
    localparam int NUM_EV     = 3;

    // Peak hold is wide enough for both the sample magnitude and the level field
    localparam int PEAK_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    // Stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = CMD_W + IDX_W;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = KIND_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_PERIOD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_NUMBER = 1'b1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BLOCK_END = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP      = 2'd3;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_STATE = 2'd0;
    localparam logic [KIND_W-1:0] EV_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] EV_PEAK  = 2'd2;

    // Bit positions in the pending-event mask, in delivery order
    localparam int EVB_STATE = 0;
    localparam int EVB_DONE  = 1;
    localparam int EVB_PEAK  = 2;

    // Silent-block counter limits
    localparam logic [SILENT_W-1:0] SILENT_MAX = 2'd3;
    localparam logic [SILENT_W-1:0] DONE_AT    = 2'd2;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Events raised by one end of block
    typedef struct packed {
        logic [NUM_EV-1:0]  mask;
        logic               running;
        logic [LEVEL_W-1:0] peak;
        logic [ID_W-1:0]    id;
    } t_bundle;

    // Absolute value; negative full scale maps onto the sign weight
    function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] m;
        m = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/vapm_core.sv =====
`default_nettype none

module vapm_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire vapm_pkg::t_cfg_wr              i_cfg,
    input  wire logic                           i_tvalid,
    output      logic                           o_tready,
    input  wire logic [vapm_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [vapm_pkg::IDX_W-1:0]     i_idx,
    input  wire logic [vapm_pkg::SAMPLE_W-1:0]  i_sample,
    output      logic                           o_bnd_vld,
    input  wire logic                           i_bnd_rdy,
    output      vapm_pkg::t_bundle              o_bnd
);

    // Input register
    logic                                r_in_vld;
    logic [vapm_pkg::CMD_W-1:0]          r_cmd;
    logic [vapm_pkg::IDX_W-1:0]          r_idx;
    logic [vapm_pkg::SAMPLE_BITS-1:0]    r_smp;

    // Configuration
    logic [vapm_pkg::PERIOD_W-1:0]       r_period;
    logic [vapm_pkg::ID_W-1:0]           r_voice_id;

    // Voice state
    logic [vapm_pkg::NUM_INPUTS-1:0]     r_run,       n_run;
    logic                                r_voice,     n_voice;
    logic                                r_reported,  n_reported;
    logic [vapm_pkg::SILENT_W-1:0]       r_silent,    n_silent;
    logic [vapm_pkg::PEAK_W-1:0]         r_peak,      n_peak;
    logic [vapm_pkg::PERIOD_W-1:0]       r_countdown, n_countdown;

    logic [vapm_pkg::NUM_INPUTS-1:0]     hit;
    logic                                idx_ok;
    logic [vapm_pkg::PEAK_W-1:0]         mag;
    logic [vapm_pkg::SILENT_W-1:0]       silent_inc;
    logic [vapm_pkg::PERIOD_W-1:0]       period_eff;
    logic [vapm_pkg::NUM_EV-1:0]         ev_mask;
    logic                                is_block_end;
    logic                                adv;

    // Decode the addressed input
    always_comb begin
        for (int i = 0; i < vapm_pkg::NUM_INPUTS; i++) begin
            hit[i] = (int'(r_idx) == i);
        end
    end

    assign idx_ok       = int'(r_idx) < vapm_pkg::NUM_INPUTS;
    assign mag          = vapm_pkg::PEAK_W'(vapm_pkg::magnitude(r_smp));
    assign period_eff   = (r_period == '0) ? vapm_pkg::PERIOD_W'(1) : r_period;
    assign silent_inc   = (r_silent != vapm_pkg::SILENT_MAX) ? r_silent + 1'b1 : r_silent;
    assign is_block_end = (r_cmd == vapm_pkg::CMD_BLOCK_END);

    // Compute the next state and the events of the held request
    always_comb begin
        n_run       = r_run;
        n_voice     = r_voice;
        n_reported  = r_reported;
        n_silent    = r_silent;
        n_peak      = r_peak;
        n_countdown = r_countdown;
        ev_mask     = '0;
        case (r_cmd)
            vapm_pkg::CMD_BLOCK_END: begin
                ev_mask[vapm_pkg::EVB_STATE] = (r_reported != r_voice);
                n_reported = r_voice;
                if (!r_voice) begin
                    n_silent = silent_inc;
                    ev_mask[vapm_pkg::EVB_DONE] = (silent_inc == vapm_pkg::DONE_AT);
                end
                if (r_countdown == '0) begin
                    ev_mask[vapm_pkg::EVB_PEAK] = 1'b1;
                    n_peak      = '0;
                    n_countdown = period_eff;
                end else begin
                    n_countdown = r_countdown - 1'b1;
                end
            end
            vapm_pkg::CMD_SAMPLE: begin
                if (idx_ok && r_voice && (|(r_run & hit)) && (mag > r_peak)) begin
                    n_peak = mag;
                end
            end
            vapm_pkg::CMD_START: begin
                if (idx_ok) begin
                    n_run    = r_run | hit;
                    n_voice  = 1'b1;
                    n_silent = '0;
                end
            end
            vapm_pkg::CMD_STOP: begin
                if (idx_ok) begin
                    n_run    = r_run & ~hit;
                    n_voice  = |(r_run & ~hit);
                    n_silent = '0;
                end
            end
            default: begin
                n_run = r_run;
            end
        endcase
    end

    // Hand events to the emitter; other requests retire at once
    assign o_bnd_vld    = r_in_vld && is_block_end && (|ev_mask);
    assign o_bnd.mask    = ev_mask;
    assign o_bnd.running = r_voice;
    assign o_bnd.peak    = vapm_pkg::LEVEL_W'(r_peak);
    assign o_bnd.id      = r_voice_id;

    assign adv      = r_in_vld && (!o_bnd_vld || i_bnd_rdy);
    assign o_tready = !r_in_vld || adv;

    // Capture the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_tready) begin
            r_in_vld <= i_tvalid;
        end
        if (o_tready && i_tvalid) begin
            r_cmd <= i_cmd;
            r_idx <= i_idx;
            r_smp <= vapm_pkg::SAMPLE_BITS'(signed'(i_sample));
        end
    end

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= vapm_pkg::PERIOD_W'(1);
            r_voice_id <= '0;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                vapm_pkg::REG_PEAK_PERIOD:  r_period   <= i_cfg.data;
                vapm_pkg::REG_VOICE_NUMBER: r_voice_id <= vapm_pkg::ID_W'(i_cfg.data);
                default:                    r_period   <= r_period;
            endcase
        end
    end

    // Advance the voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_voice     <= 1'b1;
            r_reported  <= 1'b0;
            r_silent    <= '0;
            r_peak      <= '0;
            r_countdown <= vapm_pkg::PERIOD_W'(1);
        end else if (adv) begin
            r_run       <= n_run;
            r_voice     <= n_voice;
            r_reported  <= n_reported;
            r_silent    <= n_silent;
            r_peak      <= n_peak;
            r_countdown <= n_countdown;
        end
    end

`ifndef SYNTHESIS
    a_stopped_no_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_voice |-> (r_run == '0))
        else $error("voice stopped while an input still runs");

    a_silent_only_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_silent != '0) |-> !r_voice)
        else $error("silent blocks counted while voice runs");

    a_peak_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && o_bnd_vld && o_bnd.mask[vapm_pkg::EVB_PEAK]) |=> (r_peak == '0))
        else $error("peak not cleared after report");

    a_bundle_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bnd_vld |-> is_block_end)
        else $error("events raised by a non block-end request");
`endif

endmodule

`default_nettype wire

// ===== src/vapm_emit.sv =====
`default_nettype none

module vapm_emit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_bnd_vld,
    output      logic                          o_bnd_rdy,
    input  wire vapm_pkg::t_bundle             i_bnd,
    output      logic                          o_tvalid,
    input  wire logic                          i_tready,
    output      logic [vapm_pkg::KIND_W-1:0]   o_kind,
    output      logic                          o_running,
    output      logic [vapm_pkg::LEVEL_W-1:0]  o_peak,
    output      logic [vapm_pkg::ID_W-1:0]     o_id,
    output      logic                          o_tlast
);

    logic [vapm_pkg::NUM_EV-1:0]   r_mask;
    logic                          r_running;
    logic [vapm_pkg::LEVEL_W-1:0]  r_peak;
    logic [vapm_pkg::ID_W-1:0]     r_id;
    logic [vapm_pkg::NUM_EV-1:0]   rest;

    // Pick the lowest pending event
    assign rest     = r_mask & (r_mask - 1'b1);
    assign o_tvalid = |r_mask;
    assign o_tlast  = (rest == '0);

    always_comb begin
        if (r_mask[vapm_pkg::EVB_STATE]) begin
            o_kind = vapm_pkg::EV_STATE;
        end else if (r_mask[vapm_pkg::EVB_DONE]) begin
            o_kind = vapm_pkg::EV_DONE;
        end else begin
            o_kind = vapm_pkg::EV_PEAK;
        end
    end

    assign o_running = r_running;
    assign o_peak    = (o_kind == vapm_pkg::EV_PEAK) ? r_peak : '0;
    assign o_id      = r_id;

    // Take a new set once the last pending event leaves
    assign o_bnd_rdy = !o_tvalid || (i_tready && o_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_bnd_vld && o_bnd_rdy) begin
            r_mask <= i_bnd.mask;
        end else if (o_tvalid && i_tready) begin
            r_mask <= rest;
        end
        if (i_bnd_vld && o_bnd_rdy) begin
            r_running <= i_bnd.running;
            r_peak    <= i_bnd.peak;
            r_id      <= i_bnd.id;
        end
    end

`ifndef SYNTHESIS
    a_load_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_bnd_vld && o_bnd_rdy) |=> (r_mask == $past(i_bnd.mask)))
        else $error("event set lost on load");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && i_tready && o_tlast && !i_bnd_vld) |=> !o_tvalid)
        else $error("event repeated after final delivery");

    a_advance_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && i_tready && !o_tlast)
            |=> ($countones(r_mask) == $countones($past(r_mask)) - 1))
        else $error("more than one event retired per transfer");
`endif

endmodule

`default_nettype wire

// ===== src/voice_activity_peak_monitor.sv =====
// The first event of an end of block passes the core's input register and then the
// emitter's event register, and leaves later while the sink stalls. Throughput: one
// request per cycle, but an end of block that raises events waits until the emitter has
// delivered the last event of the previous set, and a stalled sink holds it.
// Reset: synchronous active-low i_rst_n clears run flags, sets the voice running,
// loads peak period 1 and voice number 0, and empties both pipeline registers.
`default_nettype none

module voice_activity_peak_monitor (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write
    input  wire logic                                i_cfg_we,
    input  wire logic [vapm_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  wire logic [vapm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Input stream
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    input  wire logic [vapm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [23:0] sample
    input  wire logic [vapm_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // [1:0] command, [4:2] input_index
    // Event stream
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output      logic [vapm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [0] voice_running,
                                                                    // [24:1] peak_level,
                                                                    // [32:25] voice_id, [39:33] zero
    output      logic [vapm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,  // [1:0] event_kind
    output      logic                                m_axis_tlast
);

    vapm_pkg::t_cfg_wr                  cfg;
    vapm_pkg::t_bundle                  bnd;
    logic                               bnd_vld;
    logic                               bnd_rdy;
    logic [vapm_pkg::KIND_W-1:0]        ev_kind;
    logic                               ev_running;
    logic [vapm_pkg::LEVEL_W-1:0]       ev_peak;
    logic [vapm_pkg::ID_W-1:0]          ev_id;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_addr;
    assign cfg.data = i_cfg_wdata;

    // Track voice state and raise block-end events
    vapm_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_cmd     (s_axis_tuser[vapm_pkg::CMD_W-1:0]),
        .i_idx     (s_axis_tuser[vapm_pkg::IN_TUSER_W-1:vapm_pkg::CMD_W]),
        .i_sample  (s_axis_tdata[vapm_pkg::SAMPLE_W-1:0]),
        .o_bnd_vld (bnd_vld),
        .i_bnd_rdy (bnd_rdy),
        .o_bnd     (bnd)
    );

    // Deliver events one per transfer
    vapm_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bnd_vld (bnd_vld),
        .o_bnd_rdy (bnd_rdy),
        .i_bnd     (bnd),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_kind    (ev_kind),
        .o_running (ev_running),
        .o_peak    (ev_peak),
        .o_id      (ev_id),
        .o_tlast   (m_axis_tlast)
    );

    // Pack the event payload
    assign m_axis_tdata = {7'b0, ev_id, ev_peak, ev_running};
    assign m_axis_tuser = ev_kind;

endmodule

`default_nettype wire
